// File: sv/apl_pkg.sv
package apl_pkg;

    localparam int unsigned LayerCountDefault = 32;
    localparam int unsigned LayerWidth        = 5;
    localparam int unsigned MsWidth           = 15;
    localparam int unsigned MoveWidth         = 16;
    localparam int unsigned CfgIndexWidth     = 2;

    localparam logic [MsWidth-1:0] HoldResetMs = MsWidth'(600);
    localparam logic [MsWidth-1:0] MsMax       = '1;

    typedef enum logic [2:0] {
        REQ_TICK   = 3'd0,
        REQ_MOTION = 3'd1,
        REQ_KEY    = 3'd2,
        REQ_POS    = 3'd3,
        REQ_REPORT = 3'd4,
        REQ_KEEP   = 3'd5
    } req_type_t;

    typedef enum logic [1:0] {
        EV_NONE       = 2'd0,
        EV_ACTIVATE   = 2'd1,
        EV_DEACTIVATE = 2'd2
    } layer_event_t;

    typedef enum logic [CfgIndexWidth-1:0] {
        CFG_TARGET_LAYER = 2'd0,
        CFG_IDLE_THRESH  = 2'd1,
        CFG_HOLD_TIME    = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [2:0]                  req_type;
        logic signed [MoveWidth-1:0] move_value;
        logic                        key_pressed;
        logic                        is_transparent;
        logic                        layer_still_on;
        logic                        keep_flag;
    } item_t;

    typedef struct packed {
        logic                  layer_on;
        logic [1:0]            layer_event;
        logic [LayerWidth-1:0] layer_index;
    } result_t;

endpackage

// File: sv/auto_pointer_layer_controller_unit.sv
// Pipeline: each item is held in the input register and its result in the result register.
// Throughput: one item per cycle; the input stage advances whenever the result register
// is empty or its result is transferred in the same cycle.
// Reset: asynchronous, active low; clears the layer, keep-on, idle and countdown state and
// the valid flags, and loads the registers with target 0, threshold 0 and hold time 600 ms.
module auto_pointer_layer_controller_unit #(
    parameter int unsigned LAYER_COUNT = apl_pkg::LayerCountDefault
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  apl_pkg::item_t                      item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output apl_pkg::result_t                    result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [apl_pkg::CfgIndexWidth-1:0]   cfg_index,
    input  logic [apl_pkg::MsWidth-1:0]         cfg_data
);
    import apl_pkg::*;

    localparam int unsigned LastLayer = LAYER_COUNT - 1;

    logic [LayerWidth-1:0] target_layer_reg;
    logic [MsWidth-1:0]    idle_thresh_reg;
    logic [MsWidth-1:0]    hold_time_reg;

    logic                  layer_active_reg, layer_active_next;
    logic                  keep_on_reg, keep_on_next;
    logic [MsWidth-1:0]    idle_ms_reg, idle_ms_next;
    logic [MsWidth-1:0]    countdown_ms_reg, countdown_ms_next;
    logic                  countdown_armed_reg, countdown_armed_next;

    logic                  stage_valid_reg;
    item_t                 stage_reg;
    logic                  result_valid_reg;
    result_t               result_reg, result_next;

    logic                  advance;
    logic [LayerWidth-1:0] layer_index;

    assign advance      = stage_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready   = !stage_valid_reg || advance;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_layer_reg <= '0;
            idle_thresh_reg  <= '0;
            hold_time_reg    <= HoldResetMs;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TARGET_LAYER: target_layer_reg <= cfg_data[LayerWidth-1:0];
                CFG_IDLE_THRESH:  idle_thresh_reg  <= cfg_data;
                CFG_HOLD_TIME:    hold_time_reg    <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            stage_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            stage_reg <= item;
        end
    end

    always_comb
    begin
        if (32'(target_layer_reg) > LastLayer)
        begin
            layer_index = LayerWidth'(LastLayer);
        end
        else
        begin
            layer_index = target_layer_reg;
        end
    end

    always_comb
    begin
        logic [MsWidth-1:0] count_dec;
        logic [1:0]         ev;

        layer_active_next    = layer_active_reg;
        keep_on_next         = keep_on_reg;
        idle_ms_next         = idle_ms_reg;
        countdown_ms_next    = countdown_ms_reg;
        countdown_armed_next = countdown_armed_reg;
        ev                   = EV_NONE;
        count_dec            = countdown_ms_reg;

        case (stage_reg.req_type)
            REQ_TICK:
            begin
                if (idle_ms_reg != MsMax)
                begin
                    idle_ms_next = idle_ms_reg + 1'b1;
                end
                if (countdown_armed_reg)
                begin
                    if (countdown_ms_reg != '0)
                    begin
                        count_dec = countdown_ms_reg - 1'b1;
                    end
                    countdown_ms_next = count_dec;
                    if (count_dec == '0)
                    begin
                        countdown_armed_next = 1'b0;
                        if (!keep_on_reg && layer_active_reg)
                        begin
                            layer_active_next = 1'b0;
                            ev                = EV_DEACTIVATE;
                        end
                    end
                end
            end
            REQ_MOTION:
            begin
                if (stage_reg.move_value != '0)
                begin
                    if (!layer_active_reg && idle_ms_reg >= idle_thresh_reg)
                    begin
                        layer_active_next = 1'b1;
                        ev                = EV_ACTIVATE;
                    end
                    if (layer_active_next && hold_time_reg != '0)
                    begin
                        countdown_ms_next    = hold_time_reg;
                        countdown_armed_next = 1'b1;
                    end
                end
            end
            REQ_KEY:
            begin
                if (stage_reg.key_pressed)
                begin
                    idle_ms_next = '0;
                end
            end
            REQ_POS:
            begin
                if (stage_reg.key_pressed && layer_active_reg && stage_reg.is_transparent)
                begin
                    layer_active_next    = 1'b0;
                    ev                   = EV_DEACTIVATE;
                    countdown_ms_next    = '0;
                    countdown_armed_next = 1'b0;
                end
            end
            REQ_REPORT:
            begin
                if (!stage_reg.layer_still_on && layer_active_reg)
                begin
                    layer_active_next    = 1'b0;
                    countdown_ms_next    = '0;
                    countdown_armed_next = 1'b0;
                end
            end
            REQ_KEEP:
            begin
                keep_on_next = stage_reg.keep_flag;
                if (stage_reg.keep_flag)
                begin
                    countdown_ms_next    = '0;
                    countdown_armed_next = 1'b0;
                end
                else if (layer_active_reg && hold_time_reg != '0)
                begin
                    countdown_ms_next    = hold_time_reg;
                    countdown_armed_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        result_next.layer_on    = layer_active_next;
        result_next.layer_event = ev;
        result_next.layer_index = layer_index;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layer_active_reg    <= 1'b0;
            keep_on_reg         <= 1'b0;
            idle_ms_reg         <= '0;
            countdown_ms_reg    <= '0;
            countdown_armed_reg <= 1'b0;
        end
        else if (advance)
        begin
            layer_active_reg    <= layer_active_next;
            keep_on_reg         <= keep_on_next;
            idle_ms_reg         <= idle_ms_next;
            countdown_ms_reg    <= countdown_ms_next;
            countdown_armed_reg <= countdown_armed_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    // The layer only switches on through a motion item that reports the activation.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(layer_active_reg) |-> result_valid_reg && result_reg.layer_event == EV_ACTIVATE)
        else $error("layer switched on without an activate result");

    // Switching off reports a deactivation or, for an outside report, no event.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(layer_active_reg) |-> result_valid_reg &&
            (result_reg.layer_event == EV_DEACTIVATE || result_reg.layer_event == EV_NONE))
        else $error("layer switched off with an activate result");

    // An armed countdown never sits at zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        countdown_armed_reg |-> countdown_ms_reg != '0)
        else $error("countdown armed at zero");

    // A pending result agrees with the layer state it was taken from.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> result_reg.layer_on == layer_active_reg)
        else $error("pending result disagrees with the layer state");

endmodule
